>>> rtl/core/utf8_byte_stream_decoder_top_defines.svh
// assertion macros for the utf8 byte stream decoder
// used by rtl/core/utf8_byte_stream_decoder_top.sv, needs i_clk and i_rst_n in scope
`ifndef UTF8_BYTE_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U8BSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8bsd same-cycle check failed");

// next-cycle implication, checked outside reset
`define U8BSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8bsd next-cycle check failed");

`endif

>>> rtl/core/u8bsd_pkg.sv
// shared types, constants and byte classification for the utf8 byte stream decoder
// no dependencies
`timescale 1ns / 1ps

package u8bsd_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int COUNT_W  = 3;
    localparam int PEND_W   = 2;
    localparam int CONT_W   = 6;

    localparam logic [BYTE_W-1:0] CONT_PREFIX_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PREFIX      = 8'h80;

    // what a byte means when no sequence is open
    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_CONT,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_INVALID
    } t_lead_kind;

    function automatic t_lead_kind classify(input logic [BYTE_W-1:0] b);
        t_lead_kind k;
        priority if (!b[7])                k = KIND_ASCII;
        else if (b[7:6] == 2'b10)          k = KIND_CONT;
        else if (b[7:5] == 3'b110)         k = KIND_LEAD2;
        else if (b[7:4] == 4'b1110)        k = KIND_LEAD3;
        else if (b[7:3] == 5'b11110)       k = KIND_LEAD4;
        else                               k = KIND_INVALID;
        return k;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return (b & CONT_PREFIX_MASK) == CONT_PREFIX;
    endfunction

endpackage

>>> rtl/core/utf8_byte_stream_decoder_top.sv
// utf8 byte stream decoder, top level
// depends on u8bsd_pkg and utf8_byte_stream_decoder_top_defines.svh
`timescale 1ns / 1ps
`include "utf8_byte_stream_decoder_top_defines.svh"

// usage
//   slave side: one raw utf8 byte per transfer on i_s_tdata, i_s_tlast marks
//   the last byte of a slice; a sequence still open at that byte is an error
//   master side: one result per completed character or per error;
//   o_m_tdata carries code point and byte count, o_m_tuser the error flag
//   (code point and count are zero on error); a byte that only extends an
//   open sequence gives no transfer on the master side
// path: a byte taken on the slave side goes into the input register, the decode
//   logic writes its result into the result register, and the master side
//   takes the result from there
// throughput: one byte per cycle while the result register is free or i_m_tready
//   is high; the byte decode is a small classify, mask and shift that sits between the input and result registers
// stall: when the result register is full and i_m_tready is low, a byte in the
//   input register holds and o_s_tready drops; a byte that makes no result still
//   waits for a free result register, so nothing is lost or reordered
// reset: synchronous, active low; both registers empty, decoder idle with
//   no sequence open and a cleared accumulator

module utf8_byte_stream_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_slice
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [23:21] byte_count
    output logic        o_m_tuser    // [0] decode_error
);

    // input register
    logic                            r_in_valid;
    logic [u8bsd_pkg::BYTE_W-1:0]    r_in_byte;
    logic                            r_in_last;

    // decoder state
    logic [u8bsd_pkg::PEND_W-1:0]    r_pending, n_pending;
    logic [u8bsd_pkg::COUNT_W-1:0]   r_seq_len, n_seq_len;
    logic [u8bsd_pkg::CP_W-1:0]      r_partial, n_partial;

    // result register
    logic                            r_out_valid;
    logic [u8bsd_pkg::CP_W-1:0]      r_out_cp;
    logic [u8bsd_pkg::COUNT_W-1:0]   r_out_cnt;
    logic                            r_out_err;

    // decode results for the byte in the input register
    logic                            emit;
    logic [u8bsd_pkg::CP_W-1:0]      emit_cp;
    logic [u8bsd_pkg::COUNT_W-1:0]   emit_cnt;
    logic                            emit_err;

    logic                            advance;
    logic                            out_free;
    u8bsd_pkg::t_lead_kind           kind;
    logic [u8bsd_pkg::CP_W-1:0]      cont_value;

    // result register can take a new value this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    // byte in the input register gets decoded this cycle
    assign advance    = r_in_valid && out_free;
    // input register empty or draining
    assign o_s_tready = !r_in_valid || out_free;

    assign kind       = u8bsd_pkg::classify(r_in_byte);
    assign cont_value = {r_partial[u8bsd_pkg::CP_W-u8bsd_pkg::CONT_W-1:0],
                         r_in_byte[u8bsd_pkg::CONT_W-1:0]};

    // decode of one byte against the current state
    always_comb begin
        n_pending = r_pending;
        n_seq_len = r_seq_len;
        n_partial = r_partial;
        emit      = 1'b0;
        emit_cp   = '0;
        emit_cnt  = '0;
        emit_err  = 1'b0;

        if (r_pending == '0) begin
            unique case (kind)
                u8bsd_pkg::KIND_ASCII: begin
                    emit     = 1'b1;
                    emit_cp  = u8bsd_pkg::CP_W'(r_in_byte);
                    emit_cnt = u8bsd_pkg::COUNT_W'(1);
                end
                u8bsd_pkg::KIND_LEAD2, u8bsd_pkg::KIND_LEAD3, u8bsd_pkg::KIND_LEAD4: begin
                    if (r_in_last) begin
                        // sequence cut by slice end at its lead byte
                        emit     = 1'b1;
                        emit_err = 1'b1;
                    end else begin
                        unique case (kind)
                            u8bsd_pkg::KIND_LEAD2: begin
                                n_partial = u8bsd_pkg::CP_W'(r_in_byte[4:0]);
                                n_seq_len = u8bsd_pkg::COUNT_W'(2);
                                n_pending = u8bsd_pkg::PEND_W'(1);
                            end
                            u8bsd_pkg::KIND_LEAD3: begin
                                n_partial = u8bsd_pkg::CP_W'(r_in_byte[3:0]);
                                n_seq_len = u8bsd_pkg::COUNT_W'(3);
                                n_pending = u8bsd_pkg::PEND_W'(2);
                            end
                            default: begin
                                n_partial = u8bsd_pkg::CP_W'(r_in_byte[2:0]);
                                n_seq_len = u8bsd_pkg::COUNT_W'(4);
                                n_pending = u8bsd_pkg::PEND_W'(3);
                            end
                        endcase
                    end
                end
                default: begin
                    // stray continuation or five or more leading ones
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
            endcase
        end else if (!u8bsd_pkg::is_cont(r_in_byte)) begin
            // bad continuation: drop the sequence, byte is consumed
            emit      = 1'b1;
            emit_err  = 1'b1;
            n_pending = '0;
            n_seq_len = '0;
            n_partial = '0;
        end else if (r_pending == u8bsd_pkg::PEND_W'(1)) begin
            // last continuation completes the character
            emit      = 1'b1;
            emit_cp   = cont_value;
            emit_cnt  = r_seq_len;
            n_pending = '0;
            n_seq_len = '0;
            n_partial = '0;
        end else if (r_in_last) begin
            // slice ended inside the sequence
            emit      = 1'b1;
            emit_err  = 1'b1;
            n_pending = '0;
            n_seq_len = '0;
            n_partial = '0;
        end else begin
            n_partial = cont_value;
            n_pending = r_pending - u8bsd_pkg::PEND_W'(1);
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_seq_len <= '0;
            r_partial <= '0;
        end else if (advance) begin
            r_pending <= n_pending;
            r_seq_len <= n_seq_len;
            r_partial <= n_partial;
        end
    end

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_cp  <= emit_cp;
            r_out_cnt <= emit_cnt;
            r_out_err <= emit_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cnt, r_out_cp};
    assign o_m_tuser  = r_out_err;

    // error results carry no character
    `U8BSD_ASSERT_NOW(a_err_zero, r_out_valid && r_out_err, (r_out_cp == '0) && (r_out_cnt == '0))

    // a good character is one to four bytes long
    `U8BSD_ASSERT_NOW(a_cnt_range, r_out_valid && !r_out_err, (r_out_cnt != '0) && (r_out_cnt <= 3'd4))

    // an open sequence is longer than what is still awaited
    `U8BSD_ASSERT_NOW(a_seq_len, r_pending != '0, r_seq_len > {1'b0, r_pending})

    // idle decoder keeps a clean accumulator
    `U8BSD_ASSERT_NOW(a_idle_clean, r_pending == '0, (r_seq_len == '0) && (r_partial == '0))

    // a byte that opens or extends a sequence leaves no new result behind
    `U8BSD_ASSERT_NEXT(a_no_emit, advance && !emit, !r_out_valid)

endmodule
